// File: hw/rtl/ieu_pkg.sv
// Package for the integer execute unit: payload types, class, opcode and fault codes.
// No dependencies; used by every module of the unit.
package ieu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned DIV_STEPS = XLEN;

  // Instruction classes
  localparam logic [2:0] KIND_R = 3'd0;
  localparam logic [2:0] KIND_I = 3'd1;
  localparam logic [2:0] KIND_S = 3'd2;
  localparam logic [2:0] KIND_P = 3'd3;
  localparam logic [2:0] KIND_B = 3'd4;
  localparam logic [2:0] KIND_J = 3'd5;

  // Opcodes
  localparam logic [5:0] OP_R_FIRST = 6'h01;
  localparam logic [5:0] OP_R_LAST  = 6'h08;
  localparam logic [5:0] OP_MUL     = 6'h09;
  localparam logic [5:0] OP_DIV     = 6'h0A;
  localparam logic [5:0] OP_REM     = 6'h0B;
  localparam logic [5:0] OP_MOV     = 6'h0D;
  localparam logic [5:0] OP_NOT     = 6'h0E;
  localparam logic [5:0] OP_NEG     = 6'h0F;
  localparam logic [5:0] OP_I_FIRST = 6'h10;
  localparam logic [5:0] OP_I_LAST  = 6'h17;
  localparam logic [5:0] OP_LI      = 6'h19;
  localparam logic [5:0] OP_ADDR_FIRST = 6'h1A;
  localparam logic [5:0] OP_ADDR_LAST  = 6'h1E;
  localparam logic [5:0] OP_ST_FIRST = 6'h1F;
  localparam logic [5:0] OP_ST_LAST  = 6'h21;
  localparam logic [5:0] OP_BEQ     = 6'h22;
  localparam logic [5:0] OP_BNE     = 6'h23;
  localparam logic [5:0] OP_BLE     = 6'h24;
  localparam logic [5:0] OP_BGE     = 6'h25;
  localparam logic [5:0] OP_BLEU    = 6'h26;
  localparam logic [5:0] OP_BGEU    = 6'h27;
  localparam logic [5:0] OP_JMP     = 6'h28;
  localparam logic [5:0] OP_JAL     = 6'h29;
  localparam logic [5:0] OP_JR      = 6'h2A;
  localparam logic [5:0] OP_HALT    = 6'h32;

  // ALU selects
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_AND = 3'd2;
  localparam logic [2:0] ALU_OR  = 3'd3;
  localparam logic [2:0] ALU_XOR = 3'd4;
  localparam logic [2:0] ALU_SLL = 3'd5;
  localparam logic [2:0] ALU_SRL = 3'd6;
  localparam logic [2:0] ALU_SRA = 3'd7;

  localparam logic [31:0] LINK_OFFSET = 32'd4;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DIV0  = 2'd1;
  localparam logic [1:0] FAULT_CLASS = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         opcode;
    logic [31:0]        src1_value;
    logic [31:0]        src2_value;
    logic signed [31:0] immediate;
    logic [31:0]        current_pc;
  } ieu_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [31:0] next_pc;
    logic        pc_changed;
    logic        halt_request;
    logic [1:0]  fault_code;
  } ieu_out_t;

  // Control travelling alongside the divider
  typedef struct packed {
    ieu_out_t res;
    logic     is_div;
    logic     is_rem;
    logic     neg_q;
    logic     neg_r;
  } ieu_ctl_t;

  // Divider working state: n holds dividend bits, then quotient bits
  typedef struct packed {
    logic [XLEN-1:0] n;
    logic [XLEN-1:0] r;
    logic [XLEN-1:0] d;
  } ieu_div_t;

endpackage

// File: hw/rtl/cpu_execute_stage_alu_branch.sv
// Integer execute unit: ALU, multiply, pipelined signed divide, branch and jump resolution.
// Instantiates ieu_front, ieu_div_step and ieu_back; depends on ieu_pkg.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one decoded instruction (ieu_in_t).
//   Output channel out_valid_o / out_ready_i carries one result (ieu_out_t) per item,
//   in the order the items were taken.
//   Every item passes through one decode/ALU stage, 32 divider stages of
//   one quotient bit each (one 32-bit compare and subtract per stage) and one output stage.
//   All opcodes take the same path so results never reorder.
//   Throughput is one item per cycle while out_ready_i is high; every stage has its own
//   valid bit and ready, so bubbles close up and a new item is taken while a result waits.
//   When the receiver holds out_ready_i low the result stays registered and stages
//   behind it fill up; in_ready_o drops only once every stage is full.
//   Reset clears all valid bits; data registers are not reset, and the unit needs no set-up.
module cpu_execute_stage_alu_branch (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ieu_pkg::ieu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ieu_pkg::ieu_out_t out_data_o
);
  import ieu_pkg::*;

  logic     valid_s [DIV_STEPS+1];
  logic     ready_s [DIV_STEPS+1];
  ieu_ctl_t ctl_s   [DIV_STEPS+1];
  ieu_div_t div_s   [DIV_STEPS+1];

  ieu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .ctl_o   (ctl_s[0]),
    .div_o   (div_s[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    ieu_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .ctl_i   (ctl_s[g]),
      .div_i   (div_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .ctl_o   (ctl_s[g+1]),
      .div_o   (div_s[g+1])
    );
  end

  ieu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[DIV_STEPS]),
    .ready_o (ready_s[DIV_STEPS]),
    .ctl_i   (ctl_s[DIV_STEPS]),
    .div_i   (div_s[DIV_STEPS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/ieu_front.sv
// First stage: decode, ALU, multiply, branch resolution and divider operand set-up.
// Depends on ieu_pkg.
module ieu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  ieu_pkg::ieu_in_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ieu_pkg::ieu_ctl_t ctl_o,
  output ieu_pkg::ieu_div_t div_o
);
  import ieu_pkg::*;

  logic     valid_q;
  ieu_ctl_t ctl_q, ctl_d;
  ieu_div_t div_q, div_d;
  logic     load;

  logic [31:0] a, b, imm, pc;
  logic [31:0] alu_b, alu_res, prod;
  logic [2:0]  alu_sel;
  logic        take;

  assign a   = data_i.src1_value;
  assign b   = data_i.src2_value;
  assign imm = data_i.immediate;
  assign pc  = data_i.current_pc;

  assign alu_b   = (data_i.kind == KIND_R) ? b : imm;
  assign alu_sel = (data_i.kind == KIND_R) ? 3'(data_i.opcode - OP_R_FIRST)
                                           : data_i.opcode[2:0];
  assign prod    = a * b;

  always_comb begin
    case (alu_sel)
      ALU_ADD: alu_res = a + alu_b;
      ALU_SUB: alu_res = a - alu_b;
      ALU_AND: alu_res = a & alu_b;
      ALU_OR:  alu_res = a | alu_b;
      ALU_XOR: alu_res = a ^ alu_b;
      ALU_SLL: alu_res = a << alu_b[4:0];
      ALU_SRL: alu_res = a >> alu_b[4:0];
      default: alu_res = 32'($signed(a) >>> alu_b[4:0]);
    endcase
  end

  always_comb begin
    unique case (data_i.opcode)
      OP_BEQ:  take = (a == b);
      OP_BNE:  take = (a != b);
      OP_BLE:  take = ($signed(a) <= $signed(b));
      OP_BGE:  take = ($signed(a) >= $signed(b));
      OP_BLEU: take = (a <= b);
      OP_BGEU: take = (a >= b);
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    ctl_d = '0;
    ctl_d.res.next_pc = pc;
    unique case (data_i.kind)
      KIND_R: begin
        if (data_i.opcode >= OP_R_FIRST && data_i.opcode <= OP_R_LAST) begin
          ctl_d.res.result_value = alu_res;
        end else if (data_i.opcode == OP_MUL) begin
          ctl_d.res.result_value = prod;
        end else if (data_i.opcode == OP_DIV || data_i.opcode == OP_REM) begin
          if (b == '0) begin
            ctl_d.res.fault_code = FAULT_DIV0;
          end else begin
            ctl_d.is_div = 1'b1;
            ctl_d.is_rem = (data_i.opcode == OP_REM);
          end
        end else if (data_i.opcode == OP_MOV) begin
          ctl_d.res.result_value = a;
        end else if (data_i.opcode == OP_NOT) begin
          ctl_d.res.result_value = ~a;
        end else if (data_i.opcode == OP_NEG) begin
          ctl_d.res.result_value = '0 - a;
        end
      end
      KIND_I: begin
        if (data_i.opcode >= OP_I_FIRST && data_i.opcode <= OP_I_LAST) begin
          ctl_d.res.result_value = alu_res;
        end else if (data_i.opcode == OP_LI) begin
          ctl_d.res.result_value = imm;
        end else if (data_i.opcode >= OP_ADDR_FIRST && data_i.opcode <= OP_ADDR_LAST) begin
          ctl_d.res.result_value = a + imm;
        end
      end
      KIND_S: begin
        if (data_i.opcode >= OP_ST_FIRST && data_i.opcode <= OP_ST_LAST) begin
          ctl_d.res.result_value = a + imm;
        end
      end
      KIND_P: begin
        ctl_d.res.halt_request = (data_i.opcode == OP_HALT);
      end
      KIND_B: begin
        if (take) begin
          ctl_d.res.next_pc    = pc + imm;
          ctl_d.res.pc_changed = 1'b1;
        end
      end
      KIND_J: begin
        if (data_i.opcode == OP_JMP) begin
          ctl_d.res.next_pc    = pc + imm;
          ctl_d.res.pc_changed = 1'b1;
        end else if (data_i.opcode == OP_JAL) begin
          ctl_d.res.result_value = pc + LINK_OFFSET;
          ctl_d.res.next_pc      = pc + imm;
          ctl_d.res.pc_changed   = 1'b1;
        end else if (data_i.opcode == OP_JR) begin
          ctl_d.res.result_value = pc + LINK_OFFSET;
          ctl_d.res.next_pc      = (a + imm) & ~32'd1;
          ctl_d.res.pc_changed   = 1'b1;
        end
      end
      default: begin
        ctl_d.res.fault_code = FAULT_CLASS;
      end
    endcase
    // signs for the final correction; remainder follows the dividend
    ctl_d.neg_q = a[31] ^ b[31];
    ctl_d.neg_r = a[31];
  end

  always_comb begin
    div_d.n = a[31] ? ('0 - a) : a;
    div_d.d = b[31] ? ('0 - b) : b;
    div_d.r = '0;
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctl_q <= ctl_d;
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign div_o   = div_q;

endmodule

// File: hw/rtl/ieu_div_step.sv
// One restoring-division stage: one quotient bit per item per cycle while not stalled.
// Depends on ieu_pkg.
module ieu_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ieu_pkg::ieu_ctl_t ctl_i,
  input  ieu_pkg::ieu_div_t div_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ieu_pkg::ieu_ctl_t ctl_o,
  output ieu_pkg::ieu_div_t div_o
);
  import ieu_pkg::*;

  logic            valid_q;
  ieu_ctl_t        ctl_q;
  ieu_div_t        div_q, div_d;
  logic [XLEN-1:0] shifted;
  logic            fits;

  // partial remainder stays below the divisor, at most 2^31, so the shift cannot spill
  assign shifted = {div_i.r[XLEN-2:0], div_i.n[XLEN-1]};
  assign fits    = (shifted >= div_i.d);

  always_comb begin
    div_d.d = div_i.d;
    div_d.r = fits ? (shifted - div_i.d) : shifted;
    div_d.n = {div_i.n[XLEN-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q <= ctl_i;
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign div_o   = div_q;

endmodule

// File: hw/rtl/ieu_back.sv
// Output stage: sign correction of quotient or remainder and the result register.
// Depends on ieu_pkg.
module ieu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ieu_pkg::ieu_ctl_t ctl_i,
  input  ieu_pkg::ieu_div_t div_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ieu_pkg::ieu_out_t data_o
);
  import ieu_pkg::*;

  logic     valid_q;
  ieu_out_t data_q, data_d;

  always_comb begin
    data_d = ctl_i.res;
    if (ctl_i.is_div) begin
      if (ctl_i.is_rem) begin
        data_d.result_value = ctl_i.neg_r ? ('0 - div_i.r) : div_i.r;
      end else begin
        data_d.result_value = ctl_i.neg_q ? ('0 - div_i.n) : div_i.n;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/ieu_checker.sv
// Port-level checks for the execute unit, bound to the top level.
// Depends on ieu_pkg.
module ieu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ieu_pkg::ieu_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ieu_pkg::ieu_out_t out_data_o
);
  import ieu_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item withdrawn or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fault_code == FAULT_DIV0 ||
                    out_data_o.fault_code == FAULT_CLASS)
      |-> out_data_o.result_value == '0 && !out_data_o.pc_changed &&
          !out_data_o.halt_request)
    else $error("faulting item has side effects");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.halt_request
      |-> !out_data_o.pc_changed && out_data_o.result_value == '0)
    else $error("halt with redirect or value");

endmodule

bind cpu_execute_stage_alu_branch ieu_checker u_ieu_checker (.*);

// File: tb/sv/cpu_execute_stage_alu_branch_tb.sv
// Testbench for cpu_execute_stage_alu_branch: directed and random instructions, results
// checked in order against a built-in predictor. Depends on ieu_pkg and the unit's RTL.
module cpu_execute_stage_alu_branch_tb;
  import ieu_pkg::*;

  class exec_scoreboard;
    ieu_out_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] alu_op(logic [2:0] sel, logic [31:0] a, logic [31:0] b);
      case (sel)
        ALU_ADD: return a + b;
        ALU_SUB: return a - b;
        ALU_AND: return a & b;
        ALU_OR:  return a | b;
        ALU_XOR: return a ^ b;
        ALU_SLL: return a << b[4:0];
        ALU_SRL: return a >> b[4:0];
        default: return $signed(a) >>> b[4:0];
      endcase
    endfunction

    function void note_instr(ieu_in_t x);
      ieu_out_t e;
      logic [31:0] a, b, imm, ua, ub, uq, ur;
      logic take;
      a = x.src1_value;
      b = x.src2_value;
      imm = x.immediate;
      take = 1'b0;
      e = '0;
      e.next_pc = x.current_pc;
      e.fault_code = FAULT_NONE;
      case (x.kind)
        KIND_R: begin
          if (x.opcode >= OP_R_FIRST && x.opcode <= OP_R_LAST) begin
            e.result_value = alu_op(3'(x.opcode - OP_R_FIRST), a, b);
          end else if (x.opcode == OP_MUL) begin
            e.result_value = a * b;
          end else if (x.opcode == OP_DIV || x.opcode == OP_REM) begin
            if (b == 0) begin
              e.fault_code = FAULT_DIV0;
            end else begin
              ua = a[31] ? -a : a;
              ub = b[31] ? -b : b;
              uq = ua / ub;
              ur = ua % ub;
              if (x.opcode == OP_DIV) e.result_value = (a[31] != b[31]) ? -uq : uq;
              else e.result_value = a[31] ? -ur : ur;
            end
          end else if (x.opcode == OP_MOV) begin
            e.result_value = a;
          end else if (x.opcode == OP_NOT) begin
            e.result_value = ~a;
          end else if (x.opcode == OP_NEG) begin
            e.result_value = -a;
          end
        end
        KIND_I: begin
          if (x.opcode >= OP_I_FIRST && x.opcode <= OP_I_LAST)
            e.result_value = alu_op(3'(x.opcode - OP_I_FIRST), a, imm);
          else if (x.opcode == OP_LI)
            e.result_value = imm;
          else if (x.opcode >= OP_ADDR_FIRST && x.opcode <= OP_ADDR_LAST)
            e.result_value = a + imm;
        end
        KIND_S: begin
          if (x.opcode >= OP_ST_FIRST && x.opcode <= OP_ST_LAST) e.result_value = a + imm;
        end
        KIND_P: e.halt_request = (x.opcode == OP_HALT);
        KIND_B: begin
          case (x.opcode)
            OP_BEQ:  take = (a == b);
            OP_BNE:  take = (a != b);
            OP_BLE:  take = ($signed(a) <= $signed(b));
            OP_BGE:  take = ($signed(a) >= $signed(b));
            OP_BLEU: take = (a <= b);
            OP_BGEU: take = (a >= b);
            default: take = 1'b0;
          endcase
          if (take) begin
            e.next_pc = x.current_pc + imm;
            e.pc_changed = 1'b1;
          end
        end
        KIND_J: begin
          if (x.opcode == OP_JMP || x.opcode == OP_JAL) begin
            e.next_pc = x.current_pc + imm;
            e.pc_changed = 1'b1;
            if (x.opcode == OP_JAL) e.result_value = x.current_pc + LINK_OFFSET;
          end else if (x.opcode == OP_JR) begin
            e.next_pc = (a + imm) & ~32'd1;
            e.pc_changed = 1'b1;
            e.result_value = x.current_pc + LINK_OFFSET;
          end
        end
        default: e.fault_code = FAULT_CLASS;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(ieu_out_t got);
      ieu_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.result_value !== e.result_value) begin
        $error("result_value exp %h got %h", e.result_value, got.result_value); errors++;
      end
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
      end
      if (got.pc_changed !== e.pc_changed) begin
        $error("pc_changed exp %b got %b", e.pc_changed, got.pc_changed); errors++;
      end
      if (got.halt_request !== e.halt_request) begin
        $error("halt_request exp %b got %b", e.halt_request, got.halt_request); errors++;
      end
      if (got.fault_code !== e.fault_code) begin
        $error("fault_code exp %0d got %0d", e.fault_code, got.fault_code); errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ieu_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ieu_out_t out_data_o;

  exec_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [5:0] op_list[$];

  always #6 clk_i = ~clk_i;

  cpu_execute_stage_alu_branch DUT (.*);

  // monitor: inputs and results sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_instr(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high after an accepted item unless the sender goes idle
  task automatic send_instr(ieu_in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(63);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    ieu_in_t x;
    x.src1_value = rand_operand();
    x.src2_value = ($urandom_range(3) == 0) ? x.src1_value : rand_operand();
    x.immediate  = rand_operand();
    x.current_pc = $urandom;
    if ($urandom_range(19) == 0) begin
      x.kind = 3'($urandom);
      x.opcode = 6'($urandom);
    end else begin
      x.opcode = op_list[$urandom_range(op_list.size() - 1)];
      case (x.opcode) inside
        [OP_R_FIRST:OP_NEG]: x.kind = KIND_R;
        [OP_I_FIRST:OP_ADDR_LAST]: x.kind = KIND_I;
        [OP_ST_FIRST:OP_ST_LAST]: x.kind = KIND_S;
        [OP_BEQ:OP_BGEU]: x.kind = KIND_B;
        [OP_JMP:OP_JR]: x.kind = KIND_J;
        default: x.kind = KIND_P;
      endcase
    end
    send_instr(x);
  endtask

  task automatic send_directed();
    ieu_in_t x;
    x = '{KIND_R, OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 32'sd0, 32'h100};
    send_instr(x);
    x.opcode = OP_REM; send_instr(x);
    x.src2_value = 0; send_instr(x);
    x.opcode = OP_DIV; send_instr(x);
    x = '{KIND_R, OP_DIV, 32'hFFFF_FFF9, 32'd2, 32'sd0, 32'h0}; send_instr(x);
    x.opcode = OP_REM; send_instr(x);
    x = '{KIND_R, OP_MUL, 32'h0001_0003, 32'hFFFF_0005, 32'sd0, 32'hFFFF_FFFF}; send_instr(x);
    x = '{KIND_R, 6'h0C, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -32'sd1, 32'h4}; send_instr(x);
    x = '{3'd6, OP_HALT, 32'h1, 32'h1, 32'sd1, 32'h40}; send_instr(x);
    x.kind = 3'd7; send_instr(x);
    x = '{KIND_P, OP_HALT, 32'h0, 32'h0, 32'sd0, 32'h80}; send_instr(x);
    x = '{KIND_P, 6'h3F, 32'h0, 32'h0, 32'sd0, 32'h80}; send_instr(x);
    x = '{KIND_R, 6'h08, 32'h8000_0000, 32'd63, 32'sd0, 32'h0}; send_instr(x);
    x = '{KIND_I, 6'h17, 32'h8000_0001, 32'd0, 32'sd33, 32'h0}; send_instr(x);
    x = '{KIND_I, OP_LI, 32'h0, 32'h0, 32'h8000_0000, 32'h0}; send_instr(x);
    x = '{KIND_J, OP_JR, 32'h7FFF_FFFF, 32'h0, 32'sd2, 32'hFFFF_FFFC}; send_instr(x);
    x = '{KIND_J, OP_JMP, 32'h0, 32'h0, -32'sd8, 32'h4}; send_instr(x);
    x = '{KIND_J, OP_JAL, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFC}; send_instr(x);
    x = '{KIND_B, OP_BLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd16, 32'h20}; send_instr(x);
    x.opcode = OP_BLEU; send_instr(x);
    x.opcode = OP_BGE; send_instr(x);
    x.opcode = OP_BGEU; send_instr(x);
    x = '{KIND_S, OP_ST_LAST, 32'hFFFF_FFFF, 32'h0, 32'sd1, 32'h0}; send_instr(x);
    x = '{KIND_B, 6'h30, 32'h0, 32'h0, 32'sd4, 32'h0}; send_instr(x);
  endtask

  initial begin
    for (int op = OP_R_FIRST; op <= OP_NEG; op++) if (op != 6'h0C) op_list.push_back(6'(op));
    for (int op = OP_I_FIRST; op <= OP_JR; op++) if (op != 6'h18) op_list.push_back(6'(op));
    op_list.push_back(OP_HALT);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_directed();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 7) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 67 : 7) : 0;
      repeat (270) send_random();
    end
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
